// ===== design/plwc_pkg.sv =====
// Shared types, constants and saturation helpers for the weight calibration block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package plwc_pkg;

   // Field and datapath widths
   localparam int GRAM_W = 24;             // grams fields, signed
   localparam int DIFF_W = GRAM_W + 1;     // differences of two grams values
   localparam int NUM_W  = 2 * DIFF_W + 1; // signed numerator of the interpolation
   localparam int MAG_W  = NUM_W - 1;      // magnitude of that numerator

   localparam int POINTS_DEFAULT = 8;

   // Command codes of the request word
   localparam logic CMD_WRITE   = 1'b0;
   localparam logic CMD_CONVERT = 1'b1;

   typedef logic signed [GRAM_W-1:0] grams_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [NUM_W-1:0]  num_type;
   typedef logic        [MAG_W-1:0]  mag_type;

   localparam grams_type GRAMS_MAX     = grams_type'(24'h7FFFFF);
   localparam grams_type GRAMS_MIN     = grams_type'(24'h800000);
   localparam diff_type  DIFF_POS_LIM  = diff_type'(25'sd8388607);
   localparam diff_type  DIFF_NEG_LIM  = -diff_type'(25'sd8388608);
   localparam mag_type   MAG_POS_LIM   = mag_type'(8388607);
   localparam mag_type   MAG_NEG_LIM   = mag_type'(8388608);

   // Control of the serial multiplier
   typedef struct packed {
      logic start;  // load operands and begin
      logic clear;  // zero the accumulator at start
   } mul_ctl_type;

   // A corrected value with its clip flag
   typedef struct packed {
      grams_type value;
      logic      sat;
   } result_type;

   // Clip a 25-bit difference to the grams range
   function automatic result_type clip_diff(input diff_type d);
      result_type r;
      if (d > DIFF_POS_LIM) begin
         r.value = GRAMS_MAX;
         r.sat   = 1'b1;
      end else if (d < DIFF_NEG_LIM) begin
         r.value = GRAMS_MIN;
         r.sat   = 1'b1;
      end else begin
         r.value = grams_type'(d[GRAM_W-1:0]);
         r.sat   = 1'b0;
      end
      return r;
   endfunction

   // Clip a sign and magnitude quotient to the grams range
   function automatic result_type clip_mag(input mag_type mag, input logic neg);
      result_type r;
      if (neg) begin
         if (mag > MAG_NEG_LIM) begin
            r.value = GRAMS_MIN;
            r.sat   = 1'b1;
         end else begin
            r.value = grams_type'(~mag[GRAM_W-1:0] + 24'd1);
            r.sat   = 1'b0;
         end
      end else begin
         if (mag > MAG_POS_LIM) begin
            r.value = GRAMS_MAX;
            r.sat   = 1'b1;
         end else begin
            r.value = grams_type'(mag[GRAM_W-1:0]);
            r.sat   = 1'b0;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/plwc_table.sv =====
// Calibration point store: true and shown grams per entry, one write and one read port.
// Depends on plwc_pkg. Entries read as zero until written after reset.
`default_nettype none

module plwc_table #(
   parameter int POINTS = plwc_pkg::POINTS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        wr_en,
   input  wire logic [$clog2(POINTS)-1:0]   wr_index,
   input  wire plwc_pkg::grams_type         wr_true,
   input  wire plwc_pkg::grams_type         wr_shown,
   input  wire logic [$clog2(POINTS)-1:0]   rd_index,
   output plwc_pkg::grams_type              rd_true,
   output plwc_pkg::grams_type              rd_shown
);
   import plwc_pkg::*;

   logic [POINTS-1:0] valid_ff;
   grams_type         true_ff  [POINTS];
   grams_type         shown_ff [POINTS];

   // Mark entries written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_index] <= 1'b1;
      end
   end

   // Store point data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         true_ff[wr_index]  <= wr_true;
         shown_ff[wr_index] <= wr_shown;
      end
   end

   // Unwritten entries read as zero
   assign rd_true  = valid_ff[rd_index] ? true_ff[rd_index]  : '0;
   assign rd_shown = valid_ff[rd_index] ? shown_ff[rd_index] : '0;

endmodule

`default_nettype wire

// ===== design/plwc_mul.sv =====
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle.
// Depends on plwc_pkg. Two's complement multiplier, sign bit weighted negative.
`default_nettype none

module plwc_mul (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire plwc_pkg::mul_ctl_type ctl,
   input  wire plwc_pkg::diff_type    mcand,
   input  wire plwc_pkg::diff_type    mplier,
   output logic                       done,
   output plwc_pkg::num_type          acc
);
   import plwc_pkg::*;

   localparam int STEP_W = $clog2(DIFF_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIFF_W - 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   num_type           mcand_ff;
   diff_type          mplier_ff;
   num_type           acc_ff;
   num_type           term;

   // Partial product of this step; the top bit carries negative weight
   always_comb begin
      if (!mplier_ff[0]) begin
         term = '0;
      end else if (step_ff == LAST_STEP) begin
         term = -mcand_ff;
      end else begin
         term = mcand_ff;
      end
   end

   // Sequence the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   // Shift operands and accumulate
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         mcand_ff  <= num_type'(mcand);
         mplier_ff <= mplier;
         if (ctl.clear) begin
            acc_ff <= '0;
         end
      end else if (busy_ff) begin
         mcand_ff  <= mcand_ff <<< 1;
         mplier_ff <= mplier_ff >>> 1;
         acc_ff    <= acc_ff + term;
      end
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

`default_nettype wire

// ===== design/plwc_div.sv =====
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on plwc_pkg. Returns quotient magnitude and sign separately.
`default_nettype none

module plwc_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire plwc_pkg::num_type  dividend,
   input  wire plwc_pkg::diff_type divisor,
   output logic                    done,
   output plwc_pkg::mag_type       quo_mag,
   output logic                    quo_neg
);
   import plwc_pkg::*;

   localparam int STEP_W = $clog2(MAG_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_W - 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic              neg_ff;
   mag_type           quo_ff;
   logic [DIFF_W-1:0] den_ff;
   logic [DIFF_W-1:0] rem_ff;
   logic [DIFF_W:0]   trial;
   logic              fits;
   num_type           num_abs;
   diff_type          den_abs;

   // Magnitudes of the operands at start
   assign num_abs = dividend[NUM_W-1] ? -dividend : dividend;
   assign den_abs = divisor[DIFF_W-1] ? -divisor  : divisor;

   // Shift in the next dividend bit and try the subtract
   assign trial = {rem_ff, quo_ff[MAG_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   // Sequence the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   // Remainder and quotient shift registers
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[NUM_W-1] ^ divisor[DIFF_W-1];
         quo_ff <= num_abs[MAG_W-1:0];
         den_ff <= den_abs;
         rem_ff <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= DIFF_W'(trial - {1'b0, den_ff});
         end else begin
            rem_ff <= trial[DIFF_W-1:0];
         end
         quo_ff <= {quo_ff[MAG_W-2:0], fits};
      end
   end

   assign done    = done_ff;
   assign quo_mag = quo_ff;
   assign quo_neg = neg_ff;

endmodule

`default_nettype wire

// ===== design/piecewise_linear_weight_calibration.sv =====
// Piecewise-linear weight calibration. A write word (command 0) loads one calibration
// point and gives no response; a convert word (command 1) gives one response word with
// the corrected weight, a clip flag and a zero-width-segment fault flag. A convert scans
// the point store one entry per cycle, then runs two 25-step bit-serial multiplies and a
// 50-step restoring divide before the response. Pass-through cases (disabled, too few
// points, offset mode, fault) skip the arithmetic and respond after the scan. One word is
// processed at a time; a finished response waits in its own register while the next
// request is accepted. The enable register is written through the csr port.
// Depends on plwc_pkg, plwc_table, plwc_mul and plwc_div.
`default_nettype none

module piecewise_linear_weight_calibration #(
   parameter int POINTS = plwc_pkg::POINTS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_command,
   input  wire logic [2:0]           req_point_index,
   input  wire plwc_pkg::grams_type  req_true_grams,
   input  wire plwc_pkg::grams_type  req_shown_grams,
   input  wire plwc_pkg::grams_type  req_reading_grams,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output plwc_pkg::grams_type       rsp_corrected_grams,
   output logic                      rsp_saturated,
   output logic                      rsp_fault,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic                 csr_calibration_enable
);
   import plwc_pkg::*;

   localparam int IDX_W = $clog2(POINTS);
   localparam int CNT_W = $clog2(POINTS + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(POINTS - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_PREP = 3'd2;
   localparam logic [2:0] ST_MUL1 = 3'd3;
   localparam logic [2:0] ST_MUL2 = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             enable_ff;
   logic             req_acc;
   logic             rsp_load;

   // Scan results
   grams_type x_ff;
   grams_type prev_true_ff, prev_shown_ff;
   grams_type seg_a_true_ff, seg_a_shown_ff;
   grams_type seg_b_true_ff, seg_b_shown_ff;
   grams_type p0_shown_ff;
   logic      offset_ok_ff;
   logic      stop_ff;
   logic      found_ff;
   logic      have_seg_ff;

   // Arithmetic operands and result
   diff_type   w_comb, rise_comb, d_comb;
   diff_type   w_ff, rise_ff, d_ff;
   result_type res_ff, res_in, off_res, div_res;
   logic       res_fault_ff, res_fault_in;

   // Store ports
   logic      tbl_wr_en;
   grams_type rd_true, rd_shown;

   // Unit ports
   mul_ctl_type mul_ctl;
   diff_type    mul_a, mul_b;
   logic        mul_done;
   num_type     mul_acc;
   logic        div_start;
   logic        div_done;
   mag_type     div_mag;
   logic        div_neg;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign tbl_wr_en = req_acc && (req_command == CMD_WRITE)
                      && (int'(req_point_index) < POINTS);
   assign rsp_load  = (state_ff == ST_OUT) && (!rsp_valid || rsp_ready);

   plwc_table #(.POINTS(POINTS)) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_wr_en),
      .wr_index (IDX_W'(req_point_index)),
      .wr_true  (req_true_grams),
      .wr_shown (req_shown_grams),
      .rd_index (cnt_ff[IDX_W-1:0]),
      .rd_true  (rd_true),
      .rd_shown (rd_shown)
   );

   plwc_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mul_ctl),
      .mcand  (mul_a),
      .mplier (mul_b),
      .done   (mul_done),
      .acc    (mul_acc)
   );

   plwc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_acc),
      .divisor  (w_ff),
      .done     (div_done),
      .quo_mag  (div_mag),
      .quo_neg  (div_neg)
   );

   // Segment width, rise and offset of the reading from the segment start
   assign w_comb    = diff_type'(seg_b_shown_ff) - diff_type'(seg_a_shown_ff);
   assign rise_comb = diff_type'(seg_b_true_ff) - diff_type'(seg_a_true_ff);
   assign d_comb    = diff_type'(x_ff) - diff_type'(seg_a_shown_ff);
   assign off_res   = clip_diff(diff_type'(x_ff) - diff_type'(p0_shown_ff));
   assign div_res   = clip_mag(div_mag, div_neg);

   // Sequencer: next state, unit starts and result selection
   always_comb begin
      state_in      = state_ff;
      res_in        = res_ff;
      res_fault_in  = res_fault_ff;
      mul_ctl.start = 1'b0;
      mul_ctl.clear = 1'b0;
      mul_a         = diff_type'(seg_a_true_ff);
      mul_b         = w_comb;
      div_start     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_command == CMD_CONVERT)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == LAST_CNT) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            res_in.value = x_ff;
            res_in.sat   = 1'b0;
            res_fault_in = 1'b0;
            state_in     = ST_OUT;
            if (enable_ff) begin
               if (!have_seg_ff) begin
                  if (offset_ok_ff) begin
                     res_in = off_res;
                  end
               end else if (w_comb == '0) begin
                  res_fault_in = 1'b1;
               end else begin
                  mul_ctl.start = 1'b1;
                  mul_ctl.clear = 1'b1;
                  state_in      = ST_MUL1;
               end
            end
         end
         ST_MUL1: begin
            mul_a = d_ff;
            mul_b = rise_ff;
            if (mul_done) begin
               mul_ctl.start = 1'b1;
               state_in      = ST_MUL2;
            end
         end
         ST_MUL2: begin
            mul_a = d_ff;
            mul_b = rise_ff;
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in       = div_res;
               res_fault_in = 1'b0;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         enable_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            enable_ff <= csr_calibration_enable;
         end
         if (state_ff == ST_IDLE) begin
            cnt_ff <= '0;
         end else if (state_ff == ST_SCAN && cnt_ff != LAST_CNT) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (rsp_load) begin
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   // Scan the store: find the first segment holding the reading, else keep the last one
   always_ff @(posedge clock) begin
      if (req_acc) begin
         x_ff <= req_reading_grams;
      end
      if (state_ff == ST_SCAN) begin
         if (cnt_ff == '0) begin
            prev_true_ff  <= rd_true;
            prev_shown_ff <= rd_shown;
            p0_shown_ff   <= rd_shown;
            offset_ok_ff  <= (rd_true == '0) && (rd_shown != '0);
            stop_ff       <= 1'b0;
            found_ff      <= 1'b0;
            have_seg_ff   <= 1'b0;
         end else if (!stop_ff) begin
            if (rd_true == '0) begin
               stop_ff <= 1'b1;
            end else begin
               have_seg_ff <= 1'b1;
               if (!found_ff) begin
                  seg_a_true_ff  <= prev_true_ff;
                  seg_a_shown_ff <= prev_shown_ff;
                  seg_b_true_ff  <= rd_true;
                  seg_b_shown_ff <= rd_shown;
                  if (x_ff >= prev_shown_ff && x_ff <= rd_shown) begin
                     found_ff <= 1'b1;
                  end
               end
               prev_true_ff  <= rd_true;
               prev_shown_ff <= rd_shown;
            end
         end
      end
   end

   // Hold operands and the finished result
   always_ff @(posedge clock) begin
      if (state_ff == ST_PREP) begin
         w_ff    <= w_comb;
         rise_ff <= rise_comb;
         d_ff    <= d_comb;
      end
      res_ff       <= res_in;
      res_fault_ff <= res_fault_in;
      if (rsp_load) begin
         rsp_corrected_grams <= res_ff.value;
         rsp_saturated       <= res_ff.sat;
         rsp_fault           <= res_fault_ff;
      end
   end

endmodule

`default_nettype wire
